[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies; take in by include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/wvp_pkg.sv]
// shared types, codes, constants and the saturating adder for the pitch vote unit
// no dependencies
package wvp_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_scan_state;

    localparam logic CMD_POINT  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_NOTE = 2'd2;

    localparam int TIME_W  = 24;
    localparam int NOTE_W  = 12;
    localparam int LEVEL_W = 12;
    localparam int BEST_W  = 6;
    localparam int SCORE_W = 32;
    localparam int ADD_W   = 13;

    // scores in sixteenths: 100 -> 1600, 10 -> 160
    localparam logic signed [ADD_W-1:0]   SCORE_BASE = 13'sd1600;
    localparam logic signed [SCORE_W-1:0] SCORE_PREF = 32'sd160;
    localparam logic signed [ADD_W-1:0]   ROUND_HALF = 13'sd8;
    localparam logic signed [NOTE_W-1:0]  NOTE_MIN_KEEP = -12'sd7;

    localparam logic [TIME_W-1:0] WIN_END_RST   = 24'hFF_FFFF;
    localparam logic [BEST_W-1:0] PREF_NOTE_RST = 6'd63;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_store_ctl;

    typedef struct packed {
        logic busy;
        logic clear;
    } t_scan_stat;

    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] s;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            sat_add = s[SCORE_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[SCORE_W-1:0];
        end
    endfunction

endpackage

[rtl/wvp_bin_store.sv]
// bin score memory: one write port, one registered read port, per-entry valid bits
// depends on wvp_pkg
module wvp_bin_store
    import wvp_pkg::*;
#(
    parameter int NOTE_BINS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_store_ctl                 i_ctl,
    input  logic [$clog2(NOTE_BINS)-1:0] i_rd_addr,
    input  logic [$clog2(NOTE_BINS)-1:0] i_wr_addr,
    input  logic signed [SCORE_W-1:0]  i_wr_data,
    output logic signed [SCORE_W-1:0]  o_rd_data
);

    logic signed [SCORE_W-1:0] mem [NOTE_BINS];
    logic [NOTE_BINS-1:0]      r_valid;
    logic signed [SCORE_W-1:0] r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // an entry never written since the last clear reads as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/wvp_scan.sv]
// finish sequencer: walks bins 1..NOTE_BINS-1, applies the preference, tracks the best bin
// depends on wvp_pkg
module wvp_scan
    import wvp_pkg::*;
#(
    parameter int NOTE_BINS = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [BEST_W-1:0]            i_pref_note,
    input  logic signed [SCORE_W-1:0]    i_rd_data,
    output logic                         o_rd_en,
    output logic [$clog2(NOTE_BINS)-1:0] o_rd_addr,
    output t_scan_stat                   o_stat,
    output logic                         o_valid,
    output logic [BEST_W-1:0]            o_best_note
);

    localparam int BIN_W = $clog2(NOTE_BINS);
    localparam int CMP_W = (BIN_W > BEST_W) ? BIN_W : BEST_W;
    localparam logic [BIN_W-1:0] FIRST_IDX = BIN_W'(1);
    localparam logic [BIN_W-1:0] LAST_IDX  = BIN_W'(NOTE_BINS - 1);

    t_scan_state r_state, n_state;

    logic [BIN_W-1:0]          r_idx;
    logic                      issue;
    logic                      issue_last;

    logic                      r_s1_vld, r_s1_first, r_s1_last;
    logic [BIN_W-1:0]          r_s1_idx;
    logic                      s1_is_pref;
    logic signed [SCORE_W-1:0] s1_score;

    logic                      r_s2_vld, r_s2_first, r_s2_last;
    logic [BIN_W-1:0]          r_s2_idx;
    logic signed [SCORE_W-1:0] r_s2_score;

    logic                      take;
    logic [BIN_W-1:0]          r_best_idx;
    logic signed [SCORE_W-1:0] r_best_score;
    logic                      r_out_vld;
    logic [BIN_W-1:0]          r_out_idx;
    logic [CMP_W-1:0]          out_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_go) n_state = S_ISSUE;
            S_ISSUE: if (issue_last) n_state = S_DRAIN;
            S_DRAIN: if (r_s2_vld && r_s2_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        issue = 1'b0;
        unique case (r_state)
            S_ISSUE: issue = 1'b1;
            default: issue = 1'b0;
        endcase
    end

    assign issue_last = issue && (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= issue;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_idx <= FIRST_IDX;
        end else if (issue) begin
            r_idx <= r_idx + BIN_W'(1);
        end
        r_s1_idx   <= r_idx;
        r_s1_first <= r_idx == FIRST_IDX;
        r_s1_last  <= issue_last;
    end

    // preference added on the fly while reading
    assign s1_is_pref = CMP_W'(r_s1_idx) == CMP_W'(i_pref_note);
    assign s1_score   = s1_is_pref ? sat_add(i_rd_data, SCORE_PREF) : i_rd_data;

    always_ff @(posedge i_clk) begin
        r_s2_idx   <= r_s1_idx;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_score <= s1_score;
    end

    // strict greater keeps the lowest index on a tie
    assign take = r_s2_first || (r_s2_score > r_best_score);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && take) begin
            r_best_idx   <= r_s2_idx;
            r_best_score <= r_s2_score;
        end
        if (r_s2_vld && r_s2_last) begin
            r_out_idx <= take ? r_s2_idx : r_best_idx;
        end
    end

    assign out_ext      = CMP_W'(r_out_idx);
    assign o_rd_en      = issue;
    assign o_rd_addr    = r_idx;
    assign o_stat.busy  = r_state != S_IDLE;
    assign o_stat.clear = r_s2_vld && r_s2_last;
    assign o_valid      = r_out_vld;
    assign o_best_note  = out_ext[BEST_W-1:0];

endmodule

[rtl/windowed_pitch_vote_unit.sv]
// top level of the windowed pitch vote unit: config registers, point update path,
// bin store and finish scan; depends on wvp_pkg, wvp_bin_store, wvp_scan
//
// usage
//   items arrive on start / busy: an item is taken at a clock edge with start
//   high and busy low. i_cmd selects a pitch point or a finish.
//   a pitch point inside the window adds 100 + level (sixteenths) to the bin of
//   its rounded note. points may follow back to back, one per cycle while busy
//   is low; the read-modify-write of the bin store finishes in the cycle after
//   the point is taken, with forwarding when the next point hits the same bin.
//   points produce no result.
//   a finish raises busy while the scan sequencer reads bins 1..NOTE_BINS-1
//   through the single store read port, one bin per cycle, and drains its
//   s1 and s2 pipeline registers. o_valid pulses for one cycle with
//   o_best_note at the end of the scan; in that same cycle busy is low again
//   and the store is already empty.
//   the receiver cannot stall: the result is shown for exactly one cycle.
//   reset empties the store at once (per-bin valid bits) and loads the
//   register defaults; config writes go in on any edge with i_cfg_we high outside reset
module windowed_pitch_vote_unit
    import wvp_pkg::*;
#(
    parameter int NOTE_BINS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [TIME_W-1:0]          i_point_time,
    input  logic signed [NOTE_W-1:0]   i_point_note,
    input  logic signed [LEVEL_W-1:0]  i_point_level,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [TIME_W-1:0]          i_cfg_wdata,
    output logic                       o_valid,
    output logic [BEST_W-1:0]          o_best_note
);

    localparam int BIN_W = $clog2(NOTE_BINS);
    localparam int RND_W = 8;

    // configuration registers
    logic [TIME_W-1:0] r_win_start;
    logic [TIME_W-1:0] r_win_end;
    logic [BEST_W-1:0] r_pref_note;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= WIN_END_RST;
            r_pref_note <= PREF_NOTE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_START: r_win_start <= i_cfg_wdata;
                CFG_WIN_END:   r_win_end   <= i_cfg_wdata;
                CFG_PREF_NOTE: r_pref_note <= i_cfg_wdata[BEST_W-1:0];
                default:       ;
            endcase
        end
    end

    // item acceptance
    t_scan_stat scan_stat;
    logic       accept;
    logic       pt_go;
    logic       fin_go;

    assign busy   = scan_stat.busy;
    assign accept = start && !busy;
    assign pt_go  = accept && (i_cmd == CMD_POINT);
    assign fin_go = accept && (i_cmd == CMD_FINISH);

    // bin of the point: round half away from zero, drop at -0.5 and below and at NOTE_BINS and above
    logic signed [ADD_W-1:0] rnd_sum;
    logic [RND_W-1:0]        rnd;
    logic                    in_win;
    logic                    neg_drop;
    logic                    in_range;
    logic                    pt_ok;
    logic [BIN_W-1:0]        pt_bin;
    logic signed [ADD_W-1:0] pt_add;

    assign rnd_sum  = {i_point_note[NOTE_W-1], i_point_note} + ROUND_HALF;
    assign rnd      = rnd_sum[RND_W+3:4];
    assign neg_drop = i_point_note < NOTE_MIN_KEEP;
    assign in_range = {1'b0, rnd} < (RND_W+1)'(NOTE_BINS);
    assign in_win   = (i_point_time >= r_win_start) && (i_point_time <= r_win_end);
    assign pt_ok    = in_win && !neg_drop && in_range;
    assign pt_bin   = rnd[BIN_W-1:0];
    assign pt_add   = {i_point_level[LEVEL_W-1], i_point_level} + SCORE_BASE;

    // update stage: store data arrives in the cycle after the read
    logic                      r_p_vld;
    logic [BIN_W-1:0]          r_p_bin;
    logic signed [ADD_W-1:0]   r_p_add;
    logic                      r_fwd;
    logic signed [SCORE_W-1:0] r_fwd_data;
    logic signed [SCORE_W-1:0] rd_data;
    logic signed [SCORE_W-1:0] old_score;
    logic signed [SCORE_W-1:0] wr_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_p_vld <= pt_go && pt_ok;
            // the write in flight lands on the same edge as this read, so bypass it
            r_fwd   <= pt_go && pt_ok && r_p_vld && (r_p_bin == pt_bin);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_bin    <= pt_bin;
        r_p_add    <= pt_add;
        r_fwd_data <= wr_sum;
    end

    assign old_score = r_fwd ? r_fwd_data : rd_data;
    assign wr_sum    = sat_add(old_score, {{(SCORE_W-ADD_W){r_p_add[ADD_W-1]}}, r_p_add});

    // finish scan
    logic             scan_rd_en;
    logic [BIN_W-1:0] scan_rd_addr;

    wvp_scan #(
        .NOTE_BINS (NOTE_BINS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (fin_go),
        .i_pref_note (r_pref_note),
        .i_rd_data   (rd_data),
        .o_rd_en     (scan_rd_en),
        .o_rd_addr   (scan_rd_addr),
        .o_stat      (scan_stat),
        .o_valid     (o_valid),
        .o_best_note (o_best_note)
    );

    // store: one read port shared by point path and scan, which never overlap
    t_store_ctl       store_ctl;
    logic [BIN_W-1:0] store_rd_addr;

    assign store_ctl.rd_en = (pt_go && pt_ok) || scan_rd_en;
    assign store_ctl.wr_en = r_p_vld;
    assign store_ctl.clear = scan_stat.clear;
    assign store_rd_addr   = scan_rd_en ? scan_rd_addr : pt_bin;

    wvp_bin_store #(
        .NOTE_BINS (NOTE_BINS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_addr (store_rd_addr),
        .i_wr_addr (r_p_bin),
        .i_wr_data (wr_sum),
        .o_rd_data (rd_data)
    );

endmodule

[rtl/wvp_checker.sv]
// port-level checker for the pitch vote unit, bound to the top level
// depends on wvp_pkg, assert_macros.svh and windowed_pitch_vote_unit
`include "assert_macros.svh"

module wvp_checker
    import wvp_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      i_cmd,
    input logic                      o_valid,
    input logic [BEST_W-1:0]         o_best_note
);

    // a finish always occupies the unit
    `WVP_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, start && !busy && i_cmd == CMD_FINISH, busy, "finish taken but unit not busy")

    // a point never occupies the unit and never yields a result
    `WVP_ASSERT_NEXT(a_point_quiet, i_clk, i_rst_n, start && !busy && i_cmd == CMD_POINT, !busy && !o_valid, "point item caused busy or a result")

    // result comes at the end of a scan, with the unit free again
    `WVP_ASSERT_NOW(a_result_ends_scan, i_clk, i_rst_n, o_valid, !busy && $past(busy), "result outside a finish scan")

    // the best note lies among bins 1 and up
    `WVP_ASSERT_NOW(a_result_nonzero, i_clk, i_rst_n, o_valid, o_best_note != '0, "best note of zero reported")

endmodule

bind windowed_pitch_vote_unit wvp_checker u_wvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .o_best_note (o_best_note)
);
